/* src/elias_fano_encoder_unit_defines.svh */
// Assertion macros shared by the encoder RTL.
// All three expect clk and rst_n in scope.
`ifndef ELIAS_FANO_ENCODER_UNIT_DEFINES_SVH
`define ELIAS_FANO_ENCODER_UNIT_DEFINES_SVH

// Check cond at every clock edge outside reset.
`define EFE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check cons in the cycle after ante.
`define EFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check cons in the same cycle as ante.
`define EFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* src/efe_pkg.sv */
package efe_pkg;

  localparam int POSITION_BITS = 32;
  localparam int WORD_BITS     = 64;
  localparam int INDEX_BITS    = 27;
  localparam int WIDTH_BITS    = 6;
  localparam int FILL_BITS     = 6;
  localparam int COUNT_BITS    = 33;
  localparam int CFG_BITS      = 64;
  localparam int ADDR_BITS     = 4;
  localparam int MAX_RESULTS   = 4;
  localparam int RES_CNT_BITS  = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_BITS     = $clog2(MAX_RESULTS);
  localparam int ERR_BITS      = 2;
  localparam int OUT_PAYLOAD   = INDEX_BITS + WORD_BITS + WIDTH_BITS + ERR_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_PAYLOAD + 7) / 8) * 8;
  localparam int IN_TDATA_BITS  = ((POSITION_BITS + 7) / 8) * 8;

  typedef enum logic [ERR_BITS-1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNSORTED = 2'd1,
    ERR_RANGE    = 2'd2,
    ERR_COUNT    = 2'd3
  } efe_err_t;

  typedef enum logic {
    STREAM_LOW  = 1'b0,
    STREAM_HIGH = 1'b1
  } efe_stream_t;

  typedef enum logic {
    REG_UNIVERSE = 1'b0,
    REG_COUNT    = 1'b1
  } efe_reg_t;

  typedef struct packed {
    efe_stream_t            stream_select;
    logic [INDEX_BITS-1:0]  word_num;
    logic [WORD_BITS-1:0]   word_data;
    efe_err_t               error_code;
    logic                   last_result;
  } efe_result_t;

  typedef struct packed {
    logic [RES_CNT_BITS-1:0]           count;
    logic [WIDTH_BITS-1:0]             low_width;
    efe_result_t [MAX_RESULTS-1:0]     res;
  } efe_bundle_t;

endpackage

/* src/elias_fano_encoder_unit.sv */
// Elias-Fano encoder: sorted 32-bit positions in, packed 64-bit words out.
// Input stream: in_tdata carries one position, in_tlast marks the last one of a set.
// Output stream: one transaction per finished word; out_tuser selects the low-bit
// (0) or high-bit (1) vector, out_tlast flags the final word of a set or an error.
// High words never touched are not sent and read as zero.
// APB port: universe at 0x0, value_count at 0x8; write only while idle.
// The low width is taken from these registers at the first position of a set.
// A position's results pass the input register, then the result register, and are
// offered to the receiver from the result register.
// Throughput: one position per cycle while each yields at most one word and out_tready
// is high; a position that yields more words (up to four, at a set end) holds the input
// until the single output port has drained the per-position result buffer.
// A stalled receiver holds the buffer; one more position waits in the input register.
// Sorting, range or count violations emit one error result and halt until reset.
// Reset: registers back to 1, encoding state cleared, both streams empty.
`include "elias_fano_encoder_unit_defines.svh"

module elias_fano_encoder_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [efe_pkg::IN_TDATA_BITS-1:0]      in_tdata,   // [31:0] position
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [26:0] word_num, [90:27] word_data, [96:91] low_width, [98:97] error_code
  output logic [efe_pkg::OUT_TDATA_BITS-1:0]     out_tdata,
  output logic                                   out_tuser,  // [0] stream_select
  output logic                                   out_tlast,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [efe_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [efe_pkg::CFG_BITS-1:0]           pwdata,
  output logic [efe_pkg::CFG_BITS-1:0]           prdata,
  output logic                                   pready
);

  localparam int CB = efe_pkg::COUNT_BITS;
  localparam int PB = efe_pkg::POSITION_BITS;
  localparam int RB = efe_pkg::RES_CNT_BITS;

  logic [CB-1:0]                  universe_r;
  logic [CB-1:0]                  count_r;
  logic [CB-1:0]                  count_eff;
  logic [efe_pkg::WIDTH_BITS-1:0] cfg_lw;
  logic [efe_pkg::WIDTH_BITS-1:0] cfg_lw_r;
  efe_pkg::efe_reg_t              reg_sel;

  logic                           in_valid_r;
  logic [PB-1:0]                  in_pos_r;
  logic                           in_fin_r;
  logic                           can_load;
  logic                           fire;

  efe_pkg::efe_bundle_t           bundle;
  efe_pkg::efe_bundle_t           bundle_r;
  logic [RB-1:0]                  rem_r;
  logic [efe_pkg::SLOT_BITS-1:0]  head_r;
  efe_pkg::efe_result_t           head_res;

  assign pready  = 1'b1;
  assign reg_sel = efe_pkg::efe_reg_t'(paddr[efe_pkg::ADDR_BITS-1]);

  always_comb begin
    unique case (reg_sel)
      efe_pkg::REG_UNIVERSE: prdata = efe_pkg::CFG_BITS'(universe_r);
      efe_pkg::REG_COUNT:    prdata = efe_pkg::CFG_BITS'(count_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      universe_r <= CB'(1);
      count_r    <= CB'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        efe_pkg::REG_UNIVERSE: universe_r <= pwdata[CB-1:0];
        efe_pkg::REG_COUNT:    count_r    <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // floor(log2(universe / count)) as the largest k with universe >> k >= count
  assign count_eff = (count_r == '0) ? CB'(1) : count_r;

  always_comb begin
    cfg_lw = '0;
    for (int k = 1; k <= PB; k++) begin
      if ((universe_r >> k) >= count_eff) begin
        cfg_lw = efe_pkg::WIDTH_BITS'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lw_r <= '0;
    end else begin
      cfg_lw_r <= cfg_lw;
    end
  end

  assign can_load  = (rem_r == '0) || (rem_r == RB'(1) && out_tready);
  assign fire      = in_valid_r && can_load;
  assign in_tready = !in_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_pos_r <= in_tdata[PB-1:0];
      in_fin_r <= in_tlast;
    end
  end

  efe_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .position      (in_pos_r),
    .final_item    (in_fin_r),
    .cfg_low_width (cfg_lw_r),
    .universe      (universe_r),
    .value_count   (count_r),
    .bundle        (bundle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      head_r <= '0;
    end else if (fire) begin
      rem_r  <= bundle.count;
      head_r <= '0;
    end else if (out_tvalid && out_tready) begin
      rem_r  <= rem_r - RB'(1);
      head_r <= head_r + efe_pkg::SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bundle_r <= bundle;
    end
  end

  assign head_res   = bundle_r.res[head_r];
  assign out_tvalid = rem_r != '0;
  assign out_tuser  = head_res.stream_select;
  assign out_tlast  = head_res.last_result;
  assign out_tdata  = efe_pkg::OUT_TDATA_BITS'({head_res.error_code, bundle_r.low_width,
                                                 head_res.word_data, head_res.word_num});

  `EFE_ASSERT_ALWAYS(a_rem_bound, rem_r <= RB'(efe_pkg::MAX_RESULTS), "result count overflow")
  `EFE_ASSERT_SAME(a_err_last, out_tvalid && head_res.error_code != efe_pkg::ERR_NONE, out_tlast, "error result without tlast")
  `EFE_ASSERT_NEXT(a_drain, out_tvalid && out_tready && rem_r == RB'(1) && !fire, !out_tvalid, "result repeated after drain")

endmodule

/* src/efe_core.sv */
module efe_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  logic [efe_pkg::POSITION_BITS-1:0]   position,
  input  logic                                final_item,
  input  logic [efe_pkg::WIDTH_BITS-1:0]      cfg_low_width,
  input  logic [efe_pkg::COUNT_BITS-1:0]      universe,
  input  logic [efe_pkg::COUNT_BITS-1:0]      value_count,
  output efe_pkg::efe_bundle_t                bundle
);

  localparam int PB = efe_pkg::POSITION_BITS;
  localparam int WB = efe_pkg::WORD_BITS;
  localparam int IB = efe_pkg::INDEX_BITS;
  localparam int CB = efe_pkg::COUNT_BITS;
  localparam int FB = efe_pkg::FILL_BITS;
  localparam int HB = CB + 1;

  logic [efe_pkg::WIDTH_BITS-1:0] dlw_r;
  logic [WB-1:0]                  lacc_r;
  logic [FB-1:0]                  lfill_r;
  logic [IB-1:0]                  lword_r;
  logic [WB-1:0]                  hacc_r;
  logic [IB-1:0]                  hword_r;
  logic [CB-1:0]                  idx_r;
  logic [PB-1:0]                  prev_r;
  logic                           halted_r;

  logic [efe_pkg::WIDTH_BITS-1:0] w;
  logic [CB-1:0]                  count_eff;
  efe_pkg::efe_err_t              err;
  logic [PB:0]                    mask;
  logic [PB-1:0]                  pos_low;
  logic [WB+PB-1:0]               shifted;
  logic [WB-1:0]                  merged;
  logic [FB:0]                    fill_sum;
  logic                           low_done;
  logic [WB-1:0]                  lacc_nxt;
  logic [FB-1:0]                  lfill_nxt;
  logic [IB-1:0]                  lword_nxt;
  logic [HB-1:0]                  hpos;
  logic [IB-1:0]                  hword_nxt;
  logic                           high_done;
  logic [WB-1:0]                  hacc_nxt;
  efe_pkg::efe_result_t [efe_pkg::MAX_RESULTS-1:0] cand;
  logic [efe_pkg::MAX_RESULTS-1:0]                 cand_v;
  logic [efe_pkg::RES_CNT_BITS-1:0]                slot_n;

  assign w         = (idx_r == '0) ? cfg_low_width : dlw_r;
  assign count_eff = (value_count == '0) ? CB'(1) : value_count;

  always_comb begin
    priority if (idx_r >= count_eff) begin
      err = efe_pkg::ERR_COUNT;
    end else if (idx_r != '0 && position < prev_r) begin
      err = efe_pkg::ERR_UNSORTED;
    end else if ({1'b0, position} >= universe) begin
      err = efe_pkg::ERR_RANGE;
    end else begin
      err = efe_pkg::ERR_NONE;
    end
  end

  assign mask      = ((PB + 1)'(1) << w) - (PB + 1)'(1);
  assign pos_low   = position & mask[PB-1:0];
  assign shifted   = {{WB{1'b0}}, pos_low} << lfill_r;
  assign merged    = lacc_r | shifted[WB-1:0];
  assign fill_sum  = {1'b0, lfill_r} + (FB + 1)'(w);
  assign low_done  = fill_sum[FB];
  assign lacc_nxt  = low_done ? {{(WB - PB){1'b0}}, shifted[WB+PB-1:WB]} : merged;
  assign lfill_nxt = fill_sum[FB-1:0];
  assign lword_nxt = low_done ? lword_r + IB'(1) : lword_r;

  assign hpos      = HB'(position >> w) + HB'(idx_r);
  assign hword_nxt = hpos[IB+5:6];
  assign high_done = hword_nxt != hword_r;
  assign hacc_nxt  = (high_done ? '0 : hacc_r) | (WB'(1) << hpos[5:0]);

  always_comb begin
    cand[0] = '{efe_pkg::STREAM_LOW,  lword_r,   merged,   efe_pkg::ERR_NONE, 1'b0};
    cand[1] = '{efe_pkg::STREAM_HIGH, hword_r,   hacc_r,   efe_pkg::ERR_NONE, 1'b0};
    cand[2] = '{efe_pkg::STREAM_LOW,  lword_nxt, lacc_nxt, efe_pkg::ERR_NONE, 1'b0};
    cand[3] = '{efe_pkg::STREAM_HIGH, hword_nxt, hacc_nxt, efe_pkg::ERR_NONE, 1'b1};
    cand_v  = {final_item, final_item && lfill_nxt != '0, high_done, low_done};
  end

  always_comb begin
    bundle           = '0;
    bundle.low_width = w;
    slot_n           = '0;
    if (halted_r) begin
      bundle.count = '0;
    end else if (err != efe_pkg::ERR_NONE) begin
      bundle.res[0] = '{efe_pkg::STREAM_LOW, '0, '0, err, 1'b1};
      bundle.count  = efe_pkg::RES_CNT_BITS'(1);
    end else begin
      for (int j = 0; j < efe_pkg::MAX_RESULTS; j++) begin
        if (cand_v[j]) begin
          bundle.res[slot_n[efe_pkg::SLOT_BITS-1:0]] = cand[j];
          slot_n = slot_n + efe_pkg::RES_CNT_BITS'(1);
        end
      end
      bundle.count = slot_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlw_r    <= '0;
      lacc_r   <= '0;
      lfill_r  <= '0;
      lword_r  <= '0;
      hacc_r   <= '0;
      hword_r  <= '0;
      idx_r    <= '0;
      prev_r   <= '0;
      halted_r <= 1'b0;
    end else if (fire && !halted_r) begin
      if (err != efe_pkg::ERR_NONE) begin
        halted_r <= 1'b1;
        dlw_r    <= w;
      end else if (final_item) begin
        dlw_r   <= '0;
        lacc_r  <= '0;
        lfill_r <= '0;
        lword_r <= '0;
        hacc_r  <= '0;
        hword_r <= '0;
        idx_r   <= '0;
        prev_r  <= '0;
      end else begin
        dlw_r   <= w;
        lacc_r  <= lacc_nxt;
        lfill_r <= lfill_nxt;
        lword_r <= lword_nxt;
        hacc_r  <= hacc_nxt;
        hword_r <= hword_nxt;
        idx_r   <= idx_r + CB'(1);
        prev_r  <= position;
      end
    end
  end

endmodule
